>>> src/ray_sphere_hit_sky_shader_defines.svh
// Assertion helpers for the ray/sphere shader.
`ifndef RAY_SPHERE_HIT_SKY_SHADER_DEFINES_SVH
`define RAY_SPHERE_HIT_SKY_SHADER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RSH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("rsh: implication check failed");
`define RSH_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("rsh: forbidden condition seen");
`else
`define RSH_ASSERT_IMP(label, ante, cons)
`define RSH_ASSERT_NEVER(label, expr)
`endif
`endif

>>> src/rsh_pkg.sv
`default_nettype none
package rsh_pkg;

	// one ray beat
	typedef struct packed {
		logic signed [23:0] origin_x;
		logic signed [23:0] origin_y;
		logic signed [23:0] origin_z;
		logic signed [23:0] dir_x;
		logic signed [23:0] dir_y;
		logic signed [23:0] dir_z;
	} ray_t;

	// one result beat
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        hit;
	} shade_t;

	// register indexes
	localparam logic [1:0] REG_SPHERE_X = 2'd0;
	localparam logic [1:0] REG_SPHERE_Y = 2'd1;
	localparam logic [1:0] REG_SPHERE_Z = 2'd2;
	localparam logic [1:0] REG_RADIUS   = 2'd3;

	// 0.3 in Q.30
	localparam logic [28:0] K_POINT3 = 29'd322122547;

	// sky path depth: input reg + 5 normalize, 31 sqrt, 31 divide, 3 color
	localparam int SKY_LAT  = 71;
	// stage that holds the hit decision, and the last stage before the output
	localparam int HIT_STG  = 7;
	localparam int LAST_STG = 3 + SKY_LAT;

endpackage
`default_nettype wire

>>> src/rsh_sky.sv
`default_nettype none
module rsh_sky #(
	parameter int COLOR_FRAC_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic [47:0] a,
	input  wire logic        dy_neg,
	input  wire logic [23:0] dy_mag,
	output logic      [15:0] red,
	output logic      [15:0] green
);
	import rsh_pkg::*;

	// normalize: even shift so that a lands in [2^60, 2^62)
	logic [61:0] norm_w_s   [0:5];
	logic [30:0] norm_n_s   [0:5];
	logic        norm_neg_s [0:5];

	always_ff @(posedge clk) begin
		norm_w_s[0]   <= {14'd0, a};
		norm_n_s[0]   <= {7'd0, dy_mag};
		norm_neg_s[0] <= dy_neg;
	end

	for (genvar k = 0; k < 5; k++) begin : g_norm
		localparam int SH = 2 * (16 >> k);
		always_ff @(posedge clk) begin
			if (norm_w_s[k][61 -: SH] == '0) begin
				norm_w_s[k+1] <= norm_w_s[k] << SH;
				norm_n_s[k+1] <= norm_n_s[k] << (SH / 2);
			end else begin
				norm_w_s[k+1] <= norm_w_s[k];
				norm_n_s[k+1] <= norm_n_s[k];
			end
			norm_neg_s[k+1] <= norm_neg_s[k];
		end
	end

	// square root, one result bit per stage
	logic [61:0] sq_v_s   [0:30];
	logic [32:0] sq_rem_s [0:30];
	logic [30:0] sq_q_s   [0:30];
	logic [30:0] sq_n_s   [0:30];
	logic        sq_neg_s [0:30];

	for (genvar i = 0; i < 31; i++) begin : g_sqrt
		logic [61:0] v_in;
		logic [32:0] rem_in;
		logic [30:0] q_in;
		logic [30:0] n_in;
		logic        neg_in;
		logic [34:0] rem_sh;
		logic [34:0] trial;
		if (i == 0) begin : g_first
			assign v_in   = norm_w_s[5];
			assign rem_in = '0;
			assign q_in   = '0;
			assign n_in   = norm_n_s[5];
			assign neg_in = norm_neg_s[5];
		end else begin : g_next
			assign v_in   = sq_v_s[i-1];
			assign rem_in = sq_rem_s[i-1];
			assign q_in   = sq_q_s[i-1];
			assign n_in   = sq_n_s[i-1];
			assign neg_in = sq_neg_s[i-1];
		end
		assign rem_sh = {rem_in, v_in[61:60]};
		assign trial  = {2'b00, q_in, 2'b01};
		always_ff @(posedge clk) begin
			sq_v_s[i] <= v_in << 2;
			if (rem_sh >= trial) begin
				sq_rem_s[i] <= 33'(rem_sh - trial);
				sq_q_s[i]   <= {q_in[29:0], 1'b1};
			end else begin
				sq_rem_s[i] <= rem_sh[32:0];
				sq_q_s[i]   <= {q_in[29:0], 1'b0};
			end
			sq_n_s[i]   <= n_in;
			sq_neg_s[i] <= neg_in;
		end
	end

	// restoring divide (n << 30) / len, one quotient bit per stage
	logic [30:0] dv_len_s [0:30];
	logic [30:0] dv_rem_s [0:30];
	logic [30:0] dv_q_s   [0:30];
	logic        dv_neg_s [0:30];

	for (genvar j = 0; j < 31; j++) begin : g_div
		logic [30:0] len_in;
		logic [30:0] q_in;
		logic        neg_in;
		logic [31:0] rem_sh;
		if (j == 0) begin : g_first
			assign len_in = sq_q_s[30];
			assign q_in   = '0;
			assign neg_in = sq_neg_s[30];
			assign rem_sh = {1'b0, sq_n_s[30]};
		end else begin : g_next
			assign len_in = dv_len_s[j-1];
			assign q_in   = dv_q_s[j-1];
			assign neg_in = dv_neg_s[j-1];
			assign rem_sh = {dv_rem_s[j-1], 1'b0};
		end
		always_ff @(posedge clk) begin
			if (rem_sh >= {1'b0, len_in}) begin
				dv_rem_s[j] <= 31'(rem_sh - {1'b0, len_in});
				dv_q_s[j]   <= {q_in[29:0], 1'b1};
			end else begin
				dv_rem_s[j] <= rem_sh[30:0];
				dv_q_s[j]   <= {q_in[29:0], 1'b0};
			end
			dv_len_s[j] <= len_in;
			dv_neg_s[j] <= neg_in;
		end
	end

	// gradient: t = (uy + 1) / 2, then red and green
	logic [31:0] tsum;
	logic [30:0] t30_c1;
	logic [60:0] prod_c2;
	logic [31:0] r31_c2;
	logic [60:0] g60;
	logic [60:0] g_sh;
	logic [31:0] r_sh;

	assign tsum = dv_neg_s[30] ? (32'h4000_0000 - {1'b0, dv_q_s[30]})
	                           : (32'h4000_0000 + {1'b0, dv_q_s[30]});

	always_ff @(posedge clk) begin
		t30_c1  <= tsum[31:1];
		prod_c2 <= 61'(K_POINT3) * 61'(t30_c1);
		r31_c2  <= 32'h8000_0000 - {1'b0, t30_c1};
	end

	assign g60  = 61'h1000_0000_0000_0000 - prod_c2;
	assign g_sh = g60 >> (60 - COLOR_FRAC_BITS);
	assign r_sh = r31_c2 >> (31 - COLOR_FRAC_BITS);

	always_ff @(posedge clk) begin
		red   <= (|r_sh[31:16]) ? 16'hFFFF : r_sh[15:0];
		green <= (|g_sh[60:16]) ? 16'hFFFF : g_sh[15:0];
	end

endmodule
`default_nettype wire

>>> src/ray_sphere_hit_sky_shader.sv
// Ray/sphere discriminant test with sky gradient shading.
// Throughput: one ray per clock; busy stays low, the pipeline never stalls.
// Depth is set by the 31-stage square root and the 31-stage divider.
// Reset clears the valid bits and loads the sphere registers; in-flight rays are dropped.
`default_nettype none
`include "ray_sphere_hit_sky_shader_defines.svh"
module ray_sphere_hit_sky_shader #(
	parameter int COORD_FRAC_BITS = 16,
	parameter int COLOR_FRAC_BITS = 15
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire rsh_pkg::ray_t ray,
	output logic               done,
	output rsh_pkg::shade_t    shade,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rsh_pkg::*;

	localparam logic [23:0] SZ_RST  = 24'(2**24 - 2**COORD_FRAC_BITS);
	localparam logic [22:0] SR_RST  = 23'(2**(COORD_FRAC_BITS - 1));
	localparam logic [15:0] ONE_SAT = (COLOR_FRAC_BITS >= 16) ? 16'hFFFF
	                                  : 16'(2**COLOR_FRAC_BITS);

	// sphere registers
	logic [23:0] sx_q, sy_q, sz_q;
	logic [22:0] sr_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= SZ_RST;
			sr_q <= SR_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SPHERE_X: sx_q <= pwdata[23:0];
				REG_SPHERE_Y: sy_q <= pwdata[23:0];
				REG_SPHERE_Z: sz_q <= pwdata[23:0];
				REG_RADIUS:   sr_q <= pwdata[22:0];
				default:      sx_q <= sx_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SPHERE_X: prdata = {8'd0, sx_q};
			REG_SPHERE_Y: prdata = {8'd0, sy_q};
			REG_SPHERE_Z: prdata = {8'd0, sz_q};
			REG_RADIUS:   prdata = {9'd0, sr_q};
			default:      prdata = '0;
		endcase
	end

	// valid bits
	logic v_s [1:LAST_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST_STG; k++) v_s[k] <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s[1] <= start & ~busy;
			for (int k = 2; k <= LAST_STG; k++) v_s[k] <= v_s[k-1];
			done <= v_s[LAST_STG];
		end
	end

	// s1: centre minus origin
	logic signed [24:0] cx_s1, cy_s1, cz_s1;
	logic signed [23:0] dx_s1, dy_s1, dz_s1;
	logic        [22:0] rad_s1;

	always_ff @(posedge clk) begin
		cx_s1  <= $signed({sx_q[23], sx_q}) - $signed({ray.origin_x[23], ray.origin_x});
		cy_s1  <= $signed({sy_q[23], sy_q}) - $signed({ray.origin_y[23], ray.origin_y});
		cz_s1  <= $signed({sz_q[23], sz_q}) - $signed({ray.origin_z[23], ray.origin_z});
		dx_s1  <= ray.dir_x;
		dy_s1  <= ray.dir_y;
		dz_s1  <= ray.dir_z;
		rad_s1 <= sr_q;
	end

	// s2: per-axis products
	logic signed [47:0] pa_x_s2, pa_y_s2, pa_z_s2;
	logic signed [48:0] ph_x_s2, ph_y_s2, ph_z_s2;
	logic signed [49:0] pc_x_s2, pc_y_s2, pc_z_s2;
	logic        [45:0] rr_s2;
	logic signed [23:0] dy_s2;

	always_ff @(posedge clk) begin
		pa_x_s2 <= dx_s1 * dx_s1;
		pa_y_s2 <= dy_s1 * dy_s1;
		pa_z_s2 <= dz_s1 * dz_s1;
		ph_x_s2 <= dx_s1 * cx_s1;
		ph_y_s2 <= dy_s1 * cy_s1;
		ph_z_s2 <= dz_s1 * cz_s1;
		pc_x_s2 <= cx_s1 * cx_s1;
		pc_y_s2 <= cy_s1 * cy_s1;
		pc_z_s2 <= cz_s1 * cz_s1;
		rr_s2   <= rad_s1 * rad_s1;
		dy_s2   <= dy_s1;
	end

	// s3: dot products a = d.d, h = d.oc, c = oc.oc - r^2
	logic        [47:0] a_s3;
	logic signed [50:0] h_s3;
	logic signed [51:0] c_s3;
	logic               dyneg_s3;
	logic        [23:0] dymag_s3;

	always_ff @(posedge clk) begin
		a_s3 <= 48'($unsigned(pa_x_s2) + $unsigned(pa_y_s2) + $unsigned(pa_z_s2));
		h_s3 <= 51'(ph_x_s2) + 51'(ph_y_s2) + 51'(ph_z_s2);
		c_s3 <= 52'(pc_x_s2) + 52'(pc_y_s2) + 52'(pc_z_s2) - $signed({6'd0, rr_s2});
		dyneg_s3 <= dy_s2[23];
		dymag_s3 <= dy_s2[23] ? 24'(-{dy_s2[23], dy_s2}) : 24'(dy_s2);
	end

	// s4: magnitude of h and the early hit cases
	logic [49:0] hm_s4;
	logic [49:0] a_s4;
	logic [49:0] c_s4;
	logic        early_s4;

	always_ff @(posedge clk) begin
		hm_s4    <= h_s3[50] ? 50'(-h_s3) : 50'(h_s3);
		a_s4     <= {2'd0, a_s3};
		c_s4     <= c_s3[49:0];
		early_s4 <= (a_s3 == '0) | c_s3[51] | (c_s3 == '0);
	end

	// s5: 25x25 partial products of h*h and a*c
	logic [49:0] p_hh_s5, p_hl_s5, p_ll_s5;
	logic [49:0] q_hh_s5, q_hl_s5, q_lh_s5, q_ll_s5;
	logic        early_s5;

	always_ff @(posedge clk) begin
		p_hh_s5  <= hm_s4[49:25] * hm_s4[49:25];
		p_hl_s5  <= hm_s4[49:25] * hm_s4[24:0];
		p_ll_s5  <= hm_s4[24:0] * hm_s4[24:0];
		q_hh_s5  <= a_s4[49:25] * c_s4[49:25];
		q_hl_s5  <= a_s4[49:25] * c_s4[24:0];
		q_lh_s5  <= a_s4[24:0] * c_s4[49:25];
		q_ll_s5  <= a_s4[24:0] * c_s4[24:0];
		early_s5 <= early_s4;
	end

	// s6: full-width h^2 and a*c
	logic [99:0] hsq_s6, ac_s6;
	logic        early_s6;

	always_ff @(posedge clk) begin
		hsq_s6 <= (100'(p_hh_s5) << 50) + (100'(p_hl_s5) << 26) + 100'(p_ll_s5);
		ac_s6  <= (100'(q_hh_s5) << 50) + ((100'(q_hl_s5) + 100'(q_lh_s5)) << 25)
		          + 100'(q_ll_s5);
		early_s6 <= early_s5;
	end

	// s7 and on: hit decision, delayed to meet the sky path
	logic hit_s [HIT_STG:LAST_STG];

	always_ff @(posedge clk) begin
		hit_s[HIT_STG] <= early_s6 | (hsq_s6 >= ac_s6);
		for (int k = HIT_STG + 1; k <= LAST_STG; k++) hit_s[k] <= hit_s[k-1];
	end

	// sky gradient path
	logic [15:0] sky_red, sky_green;

	rsh_sky #(
		.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
	) u_sky (
		.clk    (clk),
		.a      (a_s3),
		.dy_neg (dyneg_s3),
		.dy_mag (dymag_s3),
		.red    (sky_red),
		.green  (sky_green)
	);

	// output beat
	always_ff @(posedge clk) begin
		if (hit_s[LAST_STG]) begin
			shade.red   <= ONE_SAT;
			shade.green <= '0;
			shade.blue  <= '0;
			shade.hit   <= 1'b1;
		end else begin
			shade.red   <= sky_red;
			shade.green <= sky_green;
			shade.blue  <= ONE_SAT;
			shade.hit   <= 1'b0;
		end
	end

	`RSH_ASSERT_IMP(a_hit_is_red, done && shade.hit, shade.red == ONE_SAT && shade.green == '0 && shade.blue == '0)
	`RSH_ASSERT_IMP(a_sky_blue, done && !shade.hit, shade.blue == ONE_SAT)
	`RSH_ASSERT_NEVER(a_sky_order, done && !shade.hit && (shade.green < shade.red))

endmodule
`default_nettype wire

>>> verif/ray_sphere_hit_sky_shader_checker.sv
`timescale 1ns / 100ps
module ray_sphere_hit_sky_shader_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            busy,
	input  wire rsh_pkg::ray_t   ray,
	input  wire logic            done,
	input  wire rsh_pkg::shade_t shade,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [3:0]      paddr,
	input  wire logic [31:0]     pwdata,
	input  wire logic            pready,
	output int                   errors,
	output int                   pending
);
	import rsh_pkg::*;

	localparam int COLOR_FB = 15;
	localparam logic [63:0] Q30 = 64'd1 << 30;

	// sphere registers as the block holds them
	logic [23:0] sph_x, sph_y, sph_z;
	logic [22:0] sph_r;
	shade_t shade_q[$];

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [15:0] clip16(input logic [63:0] v);
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	// shade one ray against the current sphere
	function automatic shade_t shade_ray(input ray_t r);
		shade_t s;
		logic signed [63:0] cx, cy, cz, dx, dy, dz, a, h, c, rad;
		logic [127:0] hh, ac;
		logic [63:0] as, num, len, uy, t30, r31, g60;
		int sh;
		logic is_hit;
		dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
		cx = $signed(sph_x) - r.origin_x;
		cy = $signed(sph_y) - r.origin_y;
		cz = $signed(sph_z) - r.origin_z;
		rad = {41'd0, sph_r};
		a = dx*dx + dy*dy + dz*dz;
		h = dx*cx + dy*cy + dz*cz;
		c = cx*cx + cy*cy + cz*cz - rad*rad;
		if (a == 0 || c <= 0) begin
			is_hit = 1;
		end else begin
			hh = (h < 0) ? -h : h;
			hh = hh * hh;
			ac = 128'(a) * 128'(c);
			is_hit = hh >= ac;
		end
		if (is_hit) begin
			s = '{red: clip16(64'd1 << COLOR_FB), green: 0, blue: 0, hit: 1'b1};
			return s;
		end
		as = a;
		sh = 0;
		while (as < (64'd1 << 60)) begin
			as = as << 2;
			sh++;
		end
		len = isqrt(as);
		num = (dy < 0) ? -dy : dy;
		num = num << sh;
		uy = (num << 30) / len;
		if (uy > Q30) uy = Q30;
		t30 = ((dy < 0) ? Q30 - uy : Q30 + uy) >> 1;
		r31 = (64'd1 << 31) - t30;
		g60 = (64'd1 << 60) - 64'd322122547 * t30;
		s.red = clip16(r31 >> (31 - COLOR_FB));
		s.green = clip16(g60 >> (60 - COLOR_FB));
		s.blue = clip16(64'd1 << COLOR_FB);
		s.hit = 1'b0;
		return s;
	endfunction

	task automatic report(input string what);
		$display("%t checker: %s", $realtime, what);
		errors++;
	endtask

	assign pending = shade_q.size();

	always @(posedge clk or negedge arst_n) begin
		shade_t want;
		if (!arst_n) begin
			sph_x <= 24'd0;
			sph_y <= 24'd0;
			sph_z <= 24'hFF0000;
			sph_r <= 23'h008000;
			shade_q.delete();
			errors = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SPHERE_X: sph_x <= pwdata[23:0];
					REG_SPHERE_Y: sph_y <= pwdata[23:0];
					REG_SPHERE_Z: sph_z <= pwdata[23:0];
					REG_RADIUS:   sph_r <= pwdata[22:0];
					default:      ;
				endcase
			end
			// compare result beat with oldest expectation
			if (done) begin
				if (shade_q.size() == 0) begin
					report("result beat with nothing expected");
				end else begin
					want = shade_q.pop_front();
					if (shade.red !== want.red)
						report($sformatf("red %0d want %0d", shade.red, want.red));
					if (shade.green !== want.green)
						report($sformatf("green %0d want %0d", shade.green, want.green));
					if (shade.blue !== want.blue)
						report($sformatf("blue %0d want %0d", shade.blue, want.blue));
					if (shade.hit !== want.hit)
						report($sformatf("hit %0b want %0b", shade.hit, want.hit));
				end
			end
			// predict accepted ray beat
			if (start && !busy) shade_q.push_back(shade_ray(ray));
		end
	end
endmodule

>>> verif/ray_sphere_hit_sky_shader_tb.sv
`timescale 1ns / 100ps
module ray_sphere_hit_sky_shader_tb;
	import rsh_pkg::*;

	localparam int N_RANDOM = 530;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	ray_t ray = '0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic busy, done, pready;
	logic [31:0] prdata;
	shade_t shade;
	int errors, pending;
	int cycles = 0;

	always #5 clk = ~clk;

	ray_sphere_hit_sky_shader DUT (.*);
	ray_sphere_hit_sky_shader_checker chk (.*);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("ray_sphere_hit_sky_shader_tb: errors");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// wait for every expected result, then the pipeline depth
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LAST_STG + 10) @(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		repeat (n) @(posedge clk);
	endtask

	// one ray beat, held until accepted
	task automatic send(input ray_t r, input bit gaps);
		start <= 1;
		ray <= r;
		do @(posedge clk); while (busy);
		if (gaps && $urandom_range(0, 2) == 0) begin
			start <= 0;
			idle_gap();
		end
	endtask

	function automatic logic [23:0] q(input real v);
		return 24'($rtoi(v * 65536.0));
	endfunction

	// near the default sphere or fully random
	function automatic ray_t rand_ray(input int mode);
		ray_t r;
		if (mode == 0) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			r.origin_x = 24'($signed(24'($urandom_range(0, 8191))) - 4096);
			r.origin_y = 24'($signed(24'($urandom_range(0, 8191))) - 4096);
			r.origin_z = 24'($signed(24'($urandom_range(0, 8191))) - 4096);
			r.dir_x = 24'($urandom_range(0, 262143)) - 24'd131072;
			r.dir_y = 24'($urandom_range(0, 262143)) - 24'd131072;
			r.dir_z = -24'($urandom_range(0, 131072));
			if ($urandom_range(0, 7) == 0) r.dir_y = $urandom;
		end
		return r;
	endfunction

	initial begin
		ray_t r;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset sphere
		send('{0, 0, 0, 0, 0, 0}, 0);                          // zero direction
		send('{0, 0, 0, 0, 0, q(-1.0)}, 0);                     // straight at sphere
		send('{0, 0, 0, 0, q(1.0), 0}, 0);                      // up, sky top
		send('{0, 0, 0, 0, q(-1.0), 0}, 0);                     // down, sky bottom
		send('{0, 0, 0, q(1.0), 0, 0}, 0);                      // sideways
		send('{0, 0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 0);
		send('{0, 0, 0, 24'h800000, 24'h800000, 24'h800000}, 0);
		send('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 1, 1}, 0);
		send('{24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 1}, 0);
		send('{0, 0, q(-1.0), 0, 1, 0}, 0);                     // origin inside sphere
		send('{0, 0, 0, 0, 1, 0}, 0);                           // tiny direction
		send('{0, 0, 0, 0, 24'hFFFFFF, 0}, 0);
		send('{0, q(0.5), 0, 0, 0, q(-1.0)}, 0);                // tangent ray
		start <= 0;
		drain();

		// extremes of the sphere registers, most with bits above width set
		reg_write(REG_SPHERE_X, 32'hFF7FFFFF);
		reg_write(REG_SPHERE_Y, 32'h00800000);
		reg_write(REG_SPHERE_Z, 32'hFF800000);
		reg_write(REG_RADIUS, 32'hFFFFFFFF);
		send('{0, 0, 0, 0, 0, 1}, 0);
		send('{24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 24'h800000}, 0);
		send('{24'h7FFFFF, 24'h800000, 24'h800000, 1, 24'h800000, 24'h7FFFFF}, 0);
		start <= 0;
		drain();
		reg_write(REG_RADIUS, 32'h0);
		send('{0, 0, 0, 0, 1, 0}, 0);
		send('{24'h7FFFFF, 0, 24'h800000, 24'h800000, 0, 24'h7FFFFF}, 0);
		start <= 0;
		drain();

		// random phases over several sphere settings
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 4) begin
				reg_write(REG_SPHERE_X, 0);
				reg_write(REG_SPHERE_Y, 0);
				reg_write(REG_SPHERE_Z, 32'hFFFF0000);
				reg_write(REG_RADIUS, 32'h8000);
			end else if (ph != 0) begin
				reg_write(REG_SPHERE_X, $urandom_range(0, 65535) - 32768);
				reg_write(REG_SPHERE_Y, $urandom_range(0, 65535) - 32768);
				reg_write(REG_SPHERE_Z, $urandom_range(0, 131072) - 32'h30000);
				reg_write(REG_RADIUS, (ph == 3) ? $urandom : $urandom_range(0, 98304));
			end
			for (int i = 0; i < N_RANDOM / 5; i++) begin
				r = rand_ray(($urandom_range(0, 4) == 0) ? 0 : 1);
				send(r, (i % 40) < 30);
			end
			start <= 0;
			drain();
		end

		if (errors == 0) begin
			$display("ray_sphere_hit_sky_shader_tb: clean");
		end else begin
			$display("ray_sphere_hit_sky_shader_tb: errors");
		end
		$finish;
	end
endmodule
